// File: hw/rtl/m3i_pkg.sv
package m3i_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int SHIFT = 2 * FRACTION_BITS;
    localparam int QW = SHIFT;
    localparam int DW = 100;
    localparam int CW = 65;
    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    localparam logic [DW-1:0] NEG_LIM = DW'(64'h0000_0000_8000_0000);
    localparam logic [DW-1:0] POS_LIM = DW'(64'h0000_0000_7FFF_FFFF);

    // cofactor k = a[i0]*a[i1] - a[i2]*a[i3]
    localparam logic [3:0] COF_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef logic [8:0][31:0] t_mat;

    typedef struct packed {
        logic [8:0][63:0] adj_mag;
        logic [8:0]       neg;
        logic [8:0]       ovf;
        logic [DW-1:0]    dmag;
        logic [31:0]      det;
        logic             singular;
    } t_job;

    typedef struct packed {
        logic [8:0][DW-1:0] rem;
        logic [8:0][QW-1:0] quo;
        logic [8:0]         neg;
        logic [8:0]         ovf;
        logic [DW-1:0]      dmag;
        logic [31:0]        det;
        logic               singular;
    } t_div;

    typedef struct packed {
        logic [8:0][31:0] inv;
        logic [31:0]      det;
        logic             singular;
    } t_res;

    function automatic logic [31:0] sat32(input logic [DW-1:0] mag, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (mag > NEG_LIM) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end else begin
            r = (mag > POS_LIM) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/m3i_if.sv
interface m3i_mat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
    modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
    modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface m3i_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic signed [31:0] determinant;
    logic               singular;
    modport source(output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                   inv22, determinant, singular, input ready);
    modport sink(input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                 inv22, determinant, singular, output ready);
endinterface

// File: hw/rtl/m3i_front.sv
module m3i_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  m3i_pkg::t_mat  i_mat,
    output logic           o_valid,
    input  logic           i_ready,
    output m3i_pkg::t_job  o_job
);

    logic                              en;
    logic [6:0]                        r_v;
    logic signed [31:0]                a [9];
    logic signed [63:0]                r1_pp [9];
    logic signed [63:0]                r1_pn [9];
    logic signed [31:0]                r1_a [3];
    logic signed [31:0]                r2_a [3];
    logic signed [m3i_pkg::CW-1:0]     r2_c [9];
    logic signed [m3i_pkg::CW-1:0]     r3_c [9];
    logic signed [m3i_pkg::CW-1:0]     r4_c [9];
    logic signed [m3i_pkg::CW-1:0]     r5_c [9];
    logic signed [64:0]                r3_lo [3];
    logic signed [64:0]                r3_hi [3];
    logic signed [m3i_pkg::DW-1:0]     r4_t [3];
    logic signed [m3i_pkg::DW-1:0]     r5_det;
    logic [m3i_pkg::DW-1:0]            det_abs;
    logic [63:0]                       r6_mag [9];
    logic [8:0]                        r6_cneg;
    logic [m3i_pkg::DW-1:0]            r6_dmag;
    logic                              r6_dneg;
    logic [31:0]                       r6_det;
    logic                              r6_sing;
    m3i_pkg::t_job                     r_job;

    assign en      = !r_v[6] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[6];
    assign o_job   = r_job;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            a[i] = i_mat[i];
        end
        det_abs = r5_det[m3i_pkg::DW-1] ? m3i_pkg::DW'(-r5_det) : m3i_pkg::DW'(r5_det);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r1_pp[k] <= a[m3i_pkg::COF_IDX[k][0]] * a[m3i_pkg::COF_IDX[k][1]];
                r1_pn[k] <= a[m3i_pkg::COF_IDX[k][2]] * a[m3i_pkg::COF_IDX[k][3]];
                r2_c[k]  <= m3i_pkg::CW'(r1_pp[k]) - m3i_pkg::CW'(r1_pn[k]);
                r3_c[k]  <= r2_c[k];
                r4_c[k]  <= r3_c[k];
                r5_c[k]  <= r4_c[k];
            end
            for (int k = 0; k < 3; k++) begin
                r1_a[k]  <= a[k];
                r2_a[k]  <= r1_a[k];
                r3_lo[k] <= $signed({1'b0, r2_c[k][31:0]}) * r2_a[k];
                r3_hi[k] <= $signed(r2_c[k][64:32]) * r2_a[k];
                r4_t[k]  <= (m3i_pkg::DW'(r3_hi[k]) <<< 32) + m3i_pkg::DW'(r3_lo[k]);
            end
            r5_det <= r4_t[0] + r4_t[1] + r4_t[2];

            // classify: magnitudes, signs, determinant output
            r6_dneg <= r5_det[m3i_pkg::DW-1];
            r6_dmag <= det_abs;
            r6_sing <= (r5_det == '0);
            r6_det  <= m3i_pkg::sat32(det_abs >> m3i_pkg::SHIFT, r5_det[m3i_pkg::DW-1]);
            for (int i = 0; i < 9; i++) begin
                r6_cneg[i] <= r5_c[3 * (i % 3) + (i / 3)][m3i_pkg::CW-1];
                r6_mag[i]  <= r5_c[3 * (i % 3) + (i / 3)][m3i_pkg::CW-1]
                              ? 64'(-r5_c[3 * (i % 3) + (i / 3)])
                              : 64'(r5_c[3 * (i % 3) + (i / 3)]);
            end

            for (int i = 0; i < 9; i++) begin
                r_job.adj_mag[i] <= r6_mag[i];
                r_job.neg[i]     <= r6_cneg[i] ^ r6_dneg;
                r_job.ovf[i]     <= m3i_pkg::DW'(r6_mag[i]) >= r6_dmag;
            end
            r_job.dmag     <= r6_dmag;
            r_job.det      <= r6_det;
            r_job.singular <= r6_sing;
        end
    end

endmodule

// File: hw/rtl/m3i_queue.sv
module m3i_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  m3i_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output m3i_pkg::t_job  o_job
);

    m3i_pkg::t_job                r_mem [m3i_pkg::QDEPTH];
    logic [m3i_pkg::QAW-1:0]      r_wp;
    logic [m3i_pkg::QAW-1:0]      r_rp;
    logic [m3i_pkg::QCW-1:0]      r_cnt;
    logic                         push;
    logic                         pop;

    assign o_ready = (r_cnt != m3i_pkg::QCW'(m3i_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == m3i_pkg::QAW'(m3i_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == m3i_pkg::QAW'(m3i_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + m3i_pkg::QCW'(push) - m3i_pkg::QCW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: hw/rtl/m3i_back.sv
module m3i_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  m3i_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output m3i_pkg::t_res  o_res
);

    logic                    en;
    logic [m3i_pkg::QW:0]    r_bv;
    logic                    r_vres;
    m3i_pkg::t_div           r_d [m3i_pkg::QW+1];
    m3i_pkg::t_res           r_res;

    function automatic m3i_pkg::t_div div_step(input m3i_pkg::t_div d);
        m3i_pkg::t_div          r;
        logic [m3i_pkg::DW:0]   trial;
        r = d;
        for (int l = 0; l < 9; l++) begin
            trial = {d.rem[l], 1'b0};
            if (trial >= {1'b0, d.dmag}) begin
                r.rem[l] = m3i_pkg::DW'(trial - {1'b0, d.dmag});
                r.quo[l] = {d.quo[l][m3i_pkg::QW-2:0], 1'b1};
            end else begin
                r.rem[l] = m3i_pkg::DW'(trial);
                r.quo[l] = {d.quo[l][m3i_pkg::QW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    assign en      = !r_vres || i_ready;
    assign o_ready = en;
    assign o_valid = r_vres;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv   <= '0;
            r_vres <= 1'b0;
        end else if (en) begin
            r_bv   <= {r_bv[m3i_pkg::QW-1:0], i_valid};
            r_vres <= r_bv[m3i_pkg::QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 9; l++) begin
                r_d[0].rem[l] <= m3i_pkg::DW'(i_job.adj_mag[l]);
                r_d[0].quo[l] <= '0;
            end
            r_d[0].neg      <= i_job.neg;
            r_d[0].ovf      <= i_job.ovf;
            r_d[0].dmag     <= i_job.dmag;
            r_d[0].det      <= i_job.det;
            r_d[0].singular <= i_job.singular;
            for (int s = 1; s <= m3i_pkg::QW; s++) begin
                r_d[s] <= div_step(r_d[s-1]);
            end
            for (int l = 0; l < 9; l++) begin
                r_res.inv[l] <= r_d[m3i_pkg::QW].singular ? 32'd0 :
                    m3i_pkg::sat32(r_d[m3i_pkg::QW].ovf[l] ? {m3i_pkg::DW{1'b1}}
                                   : m3i_pkg::DW'(r_d[m3i_pkg::QW].quo[l]),
                                   r_d[m3i_pkg::QW].neg[l]);
            end
            r_res.det      <= r_d[m3i_pkg::QW].det;
            r_res.singular <= r_d[m3i_pkg::QW].singular;
        end
    end

endmodule

// File: hw/rtl/matrix3_inverse_unit.sv
// Q16.16 elements; a request passes the front-end pipeline, the job queue, the divider
// stages and the result register on its way to the result.
// Throughput: one request per cycle while the output is ready; the back end is a pipelined restoring divider,
// one quotient bit per stage, nine lanes sharing the determinant magnitude.
// Reset: synchronous, active low; clears valid flags, queue pointers and queue count only.
module matrix3_inverse_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    m3i_mat_if.sink    i_mat,
    m3i_res_if.source  o_res
);

    m3i_pkg::t_mat  mat;
    m3i_pkg::t_job  f_job;
    m3i_pkg::t_job  q_job;
    m3i_pkg::t_res  res;
    logic           f_valid;
    logic           f_ready;
    logic           q_valid;
    logic           q_ready;

    assign mat[0] = i_mat.a00;
    assign mat[1] = i_mat.a01;
    assign mat[2] = i_mat.a02;
    assign mat[3] = i_mat.a10;
    assign mat[4] = i_mat.a11;
    assign mat[5] = i_mat.a12;
    assign mat[6] = i_mat.a20;
    assign mat[7] = i_mat.a21;
    assign mat[8] = i_mat.a22;

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_mat.valid),
        .o_ready (i_mat.ready),
        .i_mat   (mat),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_job   (f_job)
    );

    m3i_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    m3i_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_job   (q_job),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (res)
    );

    assign o_res.inv00       = res.inv[0];
    assign o_res.inv01       = res.inv[1];
    assign o_res.inv02       = res.inv[2];
    assign o_res.inv10       = res.inv[3];
    assign o_res.inv11       = res.inv[4];
    assign o_res.inv12       = res.inv[5];
    assign o_res.inv20       = res.inv[6];
    assign o_res.inv21       = res.inv[7];
    assign o_res.inv22       = res.inv[8];
    assign o_res.determinant = res.det;
    assign o_res.singular    = res.singular;

`ifndef SYNTHESIS
    a_sing_det_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.singular |-> o_res.determinant == 32'd0)
        else $error("singular result with nonzero determinant");

    a_sing_inv_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.singular |-> res.inv == '0)
        else $error("singular result with nonzero inverse");

    a_front_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_job))
        else $error("front dropped a request while queue was full");
`endif

endmodule

// File: tb/sv/matrix3_inverse_unit_tb.sv
`timescale 1ns / 1ps

class m3i_inverse_board;
    m3i_pkg::t_res expected_q[$];
    int            error_count;

    function automatic logic [31:0] clamp32(logic [191:0] mag, logic neg);
        if (neg) begin
            return (mag > 192'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        end
        return (mag > 192'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic signed [191:0] minor(logic signed [31:0] p, logic signed [31:0] q,
                                                  logic signed [31:0] r, logic signed [31:0] s);
        logic signed [191:0] pp, qq, rr, ss;
        pp = p; qq = q; rr = r; ss = s;
        return pp * qq - rr * ss;
    endfunction

    function void note_matrix(logic signed [31:0] a [9]);
        m3i_pkg::t_res       res;
        logic signed [191:0] cf [9];
        logic signed [191:0] det, adj;
        logic [191:0]        dmag, amag;
        int                  r, k;
        cf[0] = minor(a[4], a[8], a[5], a[7]);
        cf[1] = minor(a[5], a[6], a[3], a[8]);
        cf[2] = minor(a[3], a[7], a[4], a[6]);
        cf[3] = minor(a[2], a[7], a[1], a[8]);
        cf[4] = minor(a[0], a[8], a[2], a[6]);
        cf[5] = minor(a[1], a[6], a[0], a[7]);
        cf[6] = minor(a[1], a[5], a[2], a[4]);
        cf[7] = minor(a[2], a[3], a[0], a[5]);
        cf[8] = minor(a[0], a[4], a[1], a[3]);
        det = cf[0] * 192'(a[0]) + cf[1] * 192'(a[1]) + cf[2] * 192'(a[2]);
        dmag = det < 0 ? -det : det;
        res.det = clamp32(dmag >> m3i_pkg::SHIFT, det < 0);
        res.singular = (det == 0);
        for (int i = 0; i < 9; i++) begin
            r = i / 3;
            k = i % 3;
            adj = cf[3 * k + r];
            amag = adj < 0 ? -adj : adj;
            res.inv[i] = res.singular ? 32'd0 :
                clamp32((amag << m3i_pkg::SHIFT) / dmag, (adj < 0) != (det < 0));
        end
        expected_q.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task check_result(m3i_pkg::t_res got);
        m3i_pkg::t_res want;
        if (expected_q.size() == 0) begin
            report("unexpected result", got.det, 0);
            return;
        end
        want = expected_q.pop_front();
        for (int i = 0; i < 9; i++)
            if (got.inv[i] !== want.inv[i]) report($sformatf("inv%0d%0d", i / 3, i % 3),
                                                   got.inv[i], want.inv[i]);
        if (got.det !== want.det) report("determinant", got.det, want.det);
        if (got.singular !== want.singular) report("singular", got.singular, want.singular);
    endtask
endclass

module matrix3_inverse_unit_tb;
    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    int   hold_cycles;
    m3i_inverse_board board;

    m3i_mat_if mat_bus();
    m3i_res_if res_bus();

    matrix3_inverse_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_bus.sink),
        .o_res  (res_bus.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] pick_elem(int mode);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom();
            4: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            default: return mode == 0 ? $urandom() :
                32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    task send_matrix(logic signed [31:0] a [9]);
        while (!no_idle && $urandom_range(0, 99) < 24) begin
            mat_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        mat_bus.valid <= 1'b1;
        {mat_bus.a00, mat_bus.a01, mat_bus.a02, mat_bus.a10, mat_bus.a11,
         mat_bus.a12, mat_bus.a20, mat_bus.a21, mat_bus.a22} <=
            {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
        do @(posedge i_clk); while (!mat_bus.ready);
        board.note_matrix(a);
    endtask

    task send_random(int count);
        logic signed [31:0] a [9];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 9; i++) a[i] = pick_elem(n % 2);
            if ($urandom_range(0, 7) == 0) begin
                // dependent rows force a singular or near-singular case
                a[6] = a[0]; a[7] = a[1]; a[8] = a[2] + $urandom_range(0, 1);
            end
            send_matrix(a);
        end
    endtask

    task drain_wait;
        mat_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // sink side
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            board.check_result('{inv: {res_bus.inv22, res_bus.inv21, res_bus.inv20,
                                       res_bus.inv12, res_bus.inv11, res_bus.inv10,
                                       res_bus.inv02, res_bus.inv01, res_bus.inv00},
                                 det: res_bus.determinant, singular: res_bus.singular});
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= no_idle || $urandom_range(0, 99) >= 24;
        end
    end

    initial begin
        logic signed [31:0] a [9];
        board = new();
        i_rst_n = 1'b0;
        no_idle = 1'b0;
        hold_cycles = 0;
        res_bus.ready = 1'b0;
        mat_bus.valid = 1'b0;
        {mat_bus.a00, mat_bus.a01, mat_bus.a02, mat_bus.a10, mat_bus.a11,
         mat_bus.a12, mat_bus.a20, mat_bus.a21, mat_bus.a22} = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity, all zero, extremes, scaled diagonal, tiny determinant
        a = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        send_matrix(a);
        a = '{default: 32'd0};
        send_matrix(a);
        a = '{default: 32'h8000_0000};
        send_matrix(a);
        a = '{default: 32'h7FFF_FFFF};
        send_matrix(a);
        a = '{32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000};
        send_matrix(a);
        a = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
        send_matrix(a);
        a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(a);
        a = '{32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 32'h10000};
        send_matrix(a);
        a = '{32'h20000, 0, 0, 0, 32'hFFFE_0000, 0, 0, 0, 32'h8000};
        send_matrix(a);
        a = '{0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'hFFFF_0000};
        send_matrix(a);
        a = '{32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
              32'h70000, 32'h80000, 32'h90000};
        send_matrix(a);
        a = '{32'h10000, 32'h20000, 32'h30000, 0, 32'h10000, 32'h40000,
              32'h50000, 32'h60000, 0};
        send_matrix(a);
        a = '{32'h8000_0000, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 32'h8000_0000, 0,
              32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF};
        send_matrix(a);

        send_random(300);
        // long output stall while requests keep coming
        hold_cycles = 200;
        send_random(100);
        drain_wait();
        no_idle = 1'b1;
        send_random(400);
        no_idle = 1'b0;
        send_random(1037);
        drain_wait();
        repeat (60) @(posedge i_clk);
        if (board.error_count == 0 && board.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_if.sv
hw/rtl/m3i_front.sv
hw/rtl/m3i_queue.sv
hw/rtl/m3i_back.sv
hw/rtl/matrix3_inverse_unit.sv
tb/sv/matrix3_inverse_unit_tb.sv
